>>> design/cfgls_pkg.sv
// Package for the config line splitter and normaliser.
// Holds result kinds, byte codes, sizing constants and the queue word type.
// No dependencies.
package cfgls_pkg;

   // Raw byte count at which a line is too long is LINE_LIMIT - 1
   localparam int LINE_LIMIT = 4096;
   localparam int RAW_W      = $clog2(LINE_LIMIT);
   localparam int LINE_W     = 16;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Input actions
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_EOF  = 1'b1;

   // Byte codes
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_NONE   = 8'h00;

   typedef enum logic [2:0] {
      KIND_CHAR    = 3'd0,
      KIND_END     = 3'd1,
      KIND_SQUOTE  = 3'd2,
      KIND_DQUOTE  = 3'd3,
      KIND_LONG    = 3'd4,
      KIND_STOPPED = 3'd5
   } kind_type;

   // One queued word: a result, optionally preceded by a collapsed space
   typedef struct packed {
      logic              space_first;
      logic [7:0]        out_char;
      kind_type          kind;
      logic              line_empty;
      logic [LINE_W-1:0] line_number;
   } entry_type;

endpackage

>>> design/cfgls_if.sv
// Stream interfaces for the config line splitter: byte input and result output.
// Depends on cfgls_pkg.
interface cfgls_req_if import cfgls_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] in_char;

   modport source (output valid, action, in_char, input ready);
   modport sink   (input valid, action, in_char, output ready);
endinterface

interface cfgls_rsp_if import cfgls_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [7:0]        out_char;
   logic [2:0]        kind;
   logic              line_empty;
   logic [LINE_W-1:0] line_number;
   logic              last;

   modport source (output valid, out_char, kind, line_empty, line_number, last, input ready);
   modport sink   (input valid, out_char, kind, line_empty, line_number, last, output ready);
endinterface

>>> design/config_line_splitter_normalizer_core.sv
// Top level of the config line splitter and normaliser.
// Depends on cfgls_pkg, cfgls_if, cfgls_front, cfgls_queue and cfgls_back.
//
// Takes one file byte (or end of file) per word on req_chan and gives the
// normalised line on rsp_chan: bytes, then a line end or an error word, each
// carrying the line number; last marks the final word of an input. A new
// input word is accepted every cycle while the four-word queue between front
// and back has room. Each result is written into a queue slot and then
// into the output register; a byte that follows a collapsed blank run gives
// two result words, a space and then the byte, and the queue is not popped
// while the byte is held. After an open-quote or too-long error every input
// returns one stopped word until reset.
module config_line_splitter_normalizer_core import cfgls_pkg::*; (
   input logic         clock,
   input logic         reset,
   cfgls_req_if.sink   req_chan,
   cfgls_rsp_if.source rsp_chan
);

   logic      accept;
   logic      push;
   logic      pop;
   logic      not_empty;
   logic      not_full;
   entry_type push_entry;
   entry_type head;

   assign req_chan.ready = not_full;
   assign accept         = req_chan.valid && not_full;

   cfgls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (req_chan.action),
      .in_char    (req_chan.in_char),
      .push       (push),
      .push_entry (push_entry)
   );

   cfgls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .not_full   (not_full)
   );

   cfgls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> design/cfgls_front.sv
// Front end: accepts bytes, tracks line and quoting state, classifies results.
// Depends on cfgls_pkg; pushes one entry_type word per accepted input that produces a result.
module cfgls_front import cfgls_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       action,
   input  logic [7:0] in_char,
   output logic       push,
   output entry_type  push_entry
);

   logic              cr_pending_ff, cr_pending_in;
   logic              lf_pending_ff, lf_pending_in;
   logic              escape_ff, escape_in;
   logic              squote_ff, squote_in;
   logic              dquote_ff, dquote_in;
   logic              space_ff, space_in;
   logic              emitted_ff, emitted_in;
   logic              comment_ff, comment_in;
   logic              stopped_ff, stopped_in;
   logic [RAW_W-1:0]  raw_ff, raw_in;
   logic [LINE_W-1:0] line_ff, line_in;

   logic              produce;
   entry_type         ent;
   logic [RAW_W:0]    raw_next;
   logic              do_finish;
   logic              do_emit;
   logic [7:0]        emit_ch;

   // Next-state and result classification
   always_comb begin
      cr_pending_in = cr_pending_ff;
      lf_pending_in = lf_pending_ff;
      escape_in     = escape_ff;
      squote_in     = squote_ff;
      dquote_in     = dquote_ff;
      space_in      = space_ff;
      emitted_in    = emitted_ff;
      comment_in    = comment_ff;
      stopped_in    = stopped_ff;
      raw_in        = raw_ff;
      line_in       = line_ff;
      produce       = 1'b0;
      do_finish     = 1'b0;
      do_emit       = 1'b0;
      emit_ch       = in_char;
      raw_next      = {1'b0, raw_ff} + {{RAW_W{1'b0}}, 1'b1};
      ent.space_first = 1'b0;
      ent.out_char    = CH_NONE;
      ent.kind        = KIND_CHAR;
      ent.line_empty  = 1'b0;
      ent.line_number = line_ff;

      if (stopped_ff) begin
         produce  = 1'b1;
         ent.kind = KIND_STOPPED;
      end else if (action == ACT_EOF) begin
         do_finish = (raw_ff != '0);
      end else if ((in_char == CH_LF && cr_pending_ff) ||
                   (in_char == CH_CR && lf_pending_ff)) begin
         // second half of a CRLF or LFCR pair
         cr_pending_in = 1'b0;
         lf_pending_in = 1'b0;
      end else if (in_char == CH_LF) begin
         lf_pending_in = 1'b1;
         do_finish     = 1'b1;
      end else if (in_char == CH_CR) begin
         cr_pending_in = 1'b1;
         do_finish     = 1'b1;
      end else begin
         cr_pending_in = 1'b0;
         lf_pending_in = 1'b0;
         raw_in        = raw_next[RAW_W-1:0];
         if (raw_next >= (RAW_W+1)'(LINE_LIMIT - 1)) begin
            produce    = 1'b1;
            ent.kind   = KIND_LONG;
            stopped_in = 1'b1;
         end else if (comment_ff) begin
            // comment text is dropped
         end else if (in_char == CH_BSLASH && !escape_ff) begin
            escape_in = 1'b1;
         end else if (escape_ff) begin
            do_emit   = 1'b1;
            escape_in = 1'b0;
         end else if ((squote_ff && in_char == CH_SQUOTE) ||
                      (dquote_ff && in_char == CH_DQUOTE)) begin
            squote_in = 1'b0;
            dquote_in = 1'b0;
            do_emit   = 1'b1;
         end else if (squote_ff || dquote_ff) begin
            do_emit = 1'b1;
         end else if (in_char == CH_SQUOTE) begin
            do_emit   = 1'b1;
            squote_in = 1'b1;
         end else if (in_char == CH_DQUOTE) begin
            do_emit   = 1'b1;
            dquote_in = 1'b1;
         end else if (in_char == CH_HASH) begin
            comment_in = 1'b1;
         end else if (in_char == CH_SPACE || in_char == CH_TAB) begin
            if (emitted_ff) space_in = 1'b1;
         end else begin
            do_emit = 1'b1;
         end
      end

      // Visible byte, preceded by a pending space if any
      if (do_emit) begin
         produce         = 1'b1;
         ent.space_first = space_ff;
         ent.out_char    = emit_ch;
         ent.kind        = KIND_CHAR;
         space_in        = 1'b0;
         emitted_in      = 1'b1;
      end

      // Line end or open-quote error
      if (do_finish) begin
         produce = 1'b1;
         if (squote_ff) begin
            ent.kind   = KIND_SQUOTE;
            stopped_in = 1'b1;
         end else if (dquote_ff) begin
            ent.kind   = KIND_DQUOTE;
            stopped_in = 1'b1;
         end else begin
            ent.kind       = KIND_END;
            ent.line_empty = !emitted_ff;
         end
         if (line_ff != {LINE_W{1'b1}}) line_in = line_ff + LINE_W'(1);
         escape_in  = 1'b0;
         squote_in  = 1'b0;
         dquote_in  = 1'b0;
         space_in   = 1'b0;
         emitted_in = 1'b0;
         comment_in = 1'b0;
         raw_in     = '0;
      end

      // End of file returns to the start-of-file state unless stopped
      if (!stopped_ff && action == ACT_EOF && !stopped_in) begin
         cr_pending_in = 1'b0;
         lf_pending_in = 1'b0;
         escape_in     = 1'b0;
         squote_in     = 1'b0;
         dquote_in     = 1'b0;
         space_in      = 1'b0;
         emitted_in    = 1'b0;
         comment_in    = 1'b0;
         raw_in        = '0;
         line_in       = LINE_W'(1);
      end
   end

   assign push       = accept && produce;
   assign push_entry = ent;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cr_pending_ff <= 1'b0;
         lf_pending_ff <= 1'b0;
         escape_ff     <= 1'b0;
         squote_ff     <= 1'b0;
         dquote_ff     <= 1'b0;
         space_ff      <= 1'b0;
         emitted_ff    <= 1'b0;
         comment_ff    <= 1'b0;
         stopped_ff    <= 1'b0;
         raw_ff        <= '0;
         line_ff       <= LINE_W'(1);
      end else if (accept) begin
         cr_pending_ff <= cr_pending_in;
         lf_pending_ff <= lf_pending_in;
         escape_ff     <= escape_in;
         squote_ff     <= squote_in;
         dquote_ff     <= dquote_in;
         space_ff      <= space_in;
         emitted_ff    <= emitted_in;
         comment_ff    <= comment_in;
         stopped_ff    <= stopped_in;
         raw_ff        <= raw_in;
         line_ff       <= line_in;
      end
   end

endmodule

>>> design/cfgls_queue.sv
// Short FIFO of entry_type words between front and back.
// Depends on cfgls_pkg.
module cfgls_queue import cfgls_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      not_empty,
   output logic      not_full
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign not_full  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign head      = slot_ff[rd_ptr_ff];

   // Occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (!push && pop) count_in = count_ff - QCNT_W'(1);
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   // Pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

endmodule

>>> design/cfgls_back.sv
// Back end: expands queued words into result words in an output register.
// Depends on cfgls_pkg and cfgls_rsp_if.
module cfgls_back import cfgls_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  entry_type      head,
   input  logic           not_empty,
   output logic           pop,
   cfgls_rsp_if.source    rsp_chan
);

   logic              out_valid_ff;
   logic [7:0]        out_char_ff;
   kind_type          kind_ff;
   logic              empty_ff;
   logic [LINE_W-1:0] line_ff;
   logic              last_ff;
   logic              second_ff;
   logic [7:0]        second_char_ff;
   logic              load_ok;

   assign load_ok = !out_valid_ff || rsp_chan.ready;
   assign pop     = load_ok && !second_ff && not_empty;

   // Output register and held byte after a collapsed space
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else if (load_ok) begin
         if (second_ff) begin
            out_valid_ff <= 1'b1;
            out_char_ff  <= second_char_ff;
            kind_ff      <= KIND_CHAR;
            empty_ff     <= 1'b0;
            last_ff      <= 1'b1;
            second_ff    <= 1'b0;
         end else if (not_empty) begin
            out_valid_ff <= 1'b1;
            kind_ff      <= head.kind;
            empty_ff     <= head.line_empty;
            line_ff      <= head.line_number;
            if (head.space_first) begin
               out_char_ff    <= CH_SPACE;
               last_ff        <= 1'b0;
               second_ff      <= 1'b1;
               second_char_ff <= head.out_char;
            end else begin
               out_char_ff <= head.out_char;
               last_ff     <= 1'b1;
            end
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_char    = out_char_ff;
   assign rsp_chan.kind        = kind_ff;
   assign rsp_chan.line_empty  = empty_ff;
   assign rsp_chan.line_number = line_ff;
   assign rsp_chan.last        = last_ff;

endmodule

>>> sim/tb.sv
// Testbench for config_line_splitter_normalizer_core: byte words in, normalised line words out.
// Depends on cfgls_pkg, the cfgls_req_if and cfgls_rsp_if interfaces and the core.
`timescale 1ns / 100ps

module tb;
   import cfgls_pkg::*;

   localparam int RANDOM_WORDS = 1450;
   localparam int QUIET_AFTER  = 1100;
   localparam int STALL_LIMIT  = 1000;
   localparam int SETTLE       = 20;

   typedef struct {
      logic [7:0]        out_char;
      kind_type          kind;
      logic              line_empty;
      logic [LINE_W-1:0] line_number;
      logic              last;
   } line_word_type;

   logic clock = 1'b0;
   logic reset;

   cfgls_req_if req_chan ();
   cfgls_rsp_if rsp_chan ();

   config_line_splitter_normalizer_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the splitter state
   logic              cr_seen, lf_seen, esc_open, in_squote, in_dquote;
   logic              blank_held, line_has_text, in_remark, halted;
   int unsigned       raw_count;
   logic [LINE_W-1:0] line_no;

   line_word_type step_words[$];
   line_word_type expected_words[$];

   int unsigned words_sent    = 0;
   int unsigned words_checked = 0;
   int unsigned fail_count    = 0;
   int unsigned stalled_cycles = 0;
   int unsigned stall_left    = 0;
   bit          quiet         = 1'b0;
   kind_type    stop_kind     = KIND_SQUOTE;

   // ---------------------------------------------------------------------
   // Line splitting and normalising, word by word
   // ---------------------------------------------------------------------
   function automatic void add_word(logic [7:0] ch, kind_type k, logic empty);
      line_word_type w;
      w.out_char    = ch;
      w.kind        = k;
      w.line_empty  = empty;
      w.line_number = line_no;
      w.last        = 1'b0;
      step_words.push_back(w);
   endfunction

   function automatic void clear_line_state();
      esc_open      = 1'b0;
      in_squote     = 1'b0;
      in_dquote     = 1'b0;
      blank_held    = 1'b0;
      line_has_text = 1'b0;
      in_remark     = 1'b0;
      raw_count     = 0;
   endfunction

   function automatic void reset_splitter();
      cr_seen = 1'b0;
      lf_seen = 1'b0;
      halted  = 1'b0;
      line_no = LINE_W'(1);
      clear_line_state();
   endfunction

   // A held blank run goes out as one space ahead of the byte
   function automatic void emit_byte(logic [7:0] ch);
      if (blank_held) begin
         add_word(CH_SPACE, KIND_CHAR, 1'b0);
         blank_held = 1'b0;
      end
      add_word(ch, KIND_CHAR, 1'b0);
      line_has_text = 1'b1;
   endfunction

   function automatic void end_line();
      if (in_squote) begin
         add_word(CH_NONE, KIND_SQUOTE, 1'b0);
         halted = 1'b1;
      end else if (in_dquote) begin
         add_word(CH_NONE, KIND_DQUOTE, 1'b0);
         halted = 1'b1;
      end else begin
         add_word(CH_NONE, KIND_END, !line_has_text);
      end
      if (line_no != {LINE_W{1'b1}})
         line_no++;
      clear_line_state();
   endfunction

   function automatic void split_and_normalise(logic act, logic [7:0] ch);
      line_word_type w;
      step_words.delete();
      if (halted) begin
         add_word(CH_NONE, KIND_STOPPED, 1'b0);
      end else if (act == ACT_EOF) begin
         if (raw_count > 0)
            end_line();
         if (!halted)
            reset_splitter();
      end else if ((ch == CH_LF && cr_seen) || (ch == CH_CR && lf_seen)) begin
         // second half of a CRLF or LFCR pair
         cr_seen = 1'b0;
         lf_seen = 1'b0;
      end else if (ch == CH_LF) begin
         lf_seen = 1'b1;
         end_line();
      end else if (ch == CH_CR) begin
         cr_seen = 1'b1;
         end_line();
      end else begin
         cr_seen = 1'b0;
         lf_seen = 1'b0;
         raw_count++;
         if (raw_count >= LINE_LIMIT - 1) begin
            add_word(CH_NONE, KIND_LONG, 1'b0);
            halted = 1'b1;
         end else if (!in_remark) begin
            if (ch == CH_BSLASH && !esc_open) begin
               esc_open = 1'b1;
            end else if (esc_open) begin
               emit_byte(ch);
               esc_open = 1'b0;
            end else if ((in_squote && ch == CH_SQUOTE) || (in_dquote && ch == CH_DQUOTE)) begin
               in_squote = 1'b0;
               in_dquote = 1'b0;
               emit_byte(ch);
            end else if (in_squote || in_dquote) begin
               emit_byte(ch);
            end else if (ch == CH_SQUOTE) begin
               emit_byte(ch);
               in_squote = 1'b1;
            end else if (ch == CH_DQUOTE) begin
               emit_byte(ch);
               in_dquote = 1'b1;
            end else if (ch == CH_HASH) begin
               in_remark = 1'b1;
            end else if (ch == CH_SPACE || ch == CH_TAB) begin
               // leading blanks are dropped
               if (line_has_text)
                  blank_held = 1'b1;
            end else begin
               emit_byte(ch);
            end
         end
      end
      if (step_words.size() > 0) begin
         w = step_words.pop_back();
         w.last = 1'b1;
         step_words.push_back(w);
      end
      foreach (step_words[i])
         expected_words.push_back(step_words[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------------
   task automatic send_word(input logic act, input logic [7:0] ch);
      if (!quiet && $urandom_range(0, 11) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.action  <= act;
      req_chan.in_char <= ch;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      split_and_normalise(act, ch);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_word(ACT_BYTE, s[i]);
   endtask

   // Close any open quote before a line break so that the block keeps running
   task automatic send_balanced(input logic act, input logic [7:0] ch);
      if ((act == ACT_EOF || ch == CH_LF || ch == CH_CR) && (in_squote || in_dquote)) begin
         if (esc_open)
            send_word(ACT_BYTE, 8'h61);
         send_word(ACT_BYTE, in_squote ? CH_SQUOTE : CH_DQUOTE);
      end
      send_word(act, ch);
   endtask

   // One config-like line: words, blank runs, quoted text, escapes, comments, noise
   task automatic send_config_line();
      logic [7:0] byte_pool[8];
      logic [7:0] mark;
      int         pick;
      byte_pool = '{CH_SPACE, CH_TAB, CH_HASH, CH_BSLASH, CH_SQUOTE, CH_DQUOTE, 8'h61, 8'h3D};
      repeat ($urandom_range(0, 7)) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            repeat ($urandom_range(1, 6))
               send_balanced(ACT_BYTE, 8'($urandom_range(8'h61, 8'h7A)));
         end else if (pick < 48) begin
            repeat ($urandom_range(1, 3))
               send_balanced(ACT_BYTE, $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
         end else if (pick < 62) begin
            mark = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            send_balanced(ACT_BYTE, mark);
            repeat ($urandom_range(0, 5)) begin
               if ($urandom_range(0, 3) == 0)
                  send_balanced(ACT_BYTE, 8'($urandom_range(0, 255)));
               else
                  send_balanced(ACT_BYTE, byte_pool[$urandom_range(0, 7)]);
            end
            send_balanced(ACT_BYTE, mark);
         end else if (pick < 70) begin
            send_balanced(ACT_BYTE, CH_BSLASH);
            send_balanced(ACT_BYTE, 8'($urandom_range(0, 255)));
         end else if (pick < 76) begin
            send_balanced(ACT_BYTE, CH_HASH);
            repeat ($urandom_range(0, 4)) send_balanced(ACT_BYTE, byte_pool[$urandom_range(0, 7)]);
         end else if (pick < 90) begin
            send_balanced(ACT_BYTE, 8'($urandom_range(0, 255)));
         end else begin
            send_balanced(ACT_BYTE, byte_pool[$urandom_range(0, 7)]);
         end
      end
      // line terminator
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         send_balanced(ACT_BYTE, CH_LF);
      end else if (pick < 55) begin
         send_balanced(ACT_BYTE, CH_CR);
      end else if (pick < 70) begin
         send_balanced(ACT_BYTE, CH_CR);
         send_balanced(ACT_BYTE, CH_LF);
      end else if (pick < 80) begin
         send_balanced(ACT_BYTE, CH_LF);
         send_balanced(ACT_BYTE, CH_CR);
      end else if (pick < 90) begin
         send_balanced(ACT_BYTE, CH_LF);
         send_balanced(ACT_BYTE, CH_LF);
      end else begin
         send_balanced(ACT_EOF, 8'($urandom_range(0, 255)));
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // CRLF and LFCR pairs, an empty line, top byte value
   task automatic test_line_breaks();
      send_word(ACT_BYTE, 8'hFF);
      send_word(ACT_BYTE, CH_CR);
      send_word(ACT_BYTE, CH_LF);
      send_word(ACT_BYTE, CH_LF);
      send_word(ACT_BYTE, CH_CR);
   endtask

   // Leading blanks, collapsed run before a byte, dangling escape and space at line end
   task automatic test_blank_runs();
      send_text(" \t");
      send_word(ACT_BYTE, 8'h00);
      send_text(" \ty \\");
      send_word(ACT_BYTE, CH_LF);
   endtask

   // Escaped hash, both quote styles copied verbatim, comment hiding a quote
   task automatic test_quotes_and_comments();
      send_text("\\#' #'\"'\"#q'");
      send_word(ACT_BYTE, CH_LF);
   endtask

   // Partial line finished at end of file, then end of file with nothing pending
   task automatic test_end_of_file();
      send_text("z");
      send_word(ACT_EOF, 8'hFF);
      send_word(ACT_EOF, 8'h00);
   endtask

   // Random config text; the last stretch runs with no idling on either side
   task automatic test_random_config();
      int unsigned start;
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         if (words_sent - start >= QUIET_AFTER)
            quiet = 1'b1;
         send_config_line();
      end
   endtask

   // One open-quote error picked at random, then stopped words until the end
   task automatic test_error_stop();
      stop_kind = kind_type'(KIND_SQUOTE + $urandom_range(0, 1));
      case (stop_kind)
         KIND_SQUOTE: begin
            send_text("k='v");
            send_word(ACT_BYTE, CH_LF);
         end
         default: begin
            send_text("k=\"v w");
            send_word(ACT_BYTE, CH_CR);
         end
      endcase
      repeat (8) send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
   endtask

   // ---------------------------------------------------------------------
   // Output side: random stall bursts, with ready raised again between them
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if (!quiet && rsp_chan.ready && $urandom_range(0, 15) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = $urandom_range(0, 18);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic void flag_mismatch(string field, int unsigned want, int unsigned got);
      fail_count++;
      if (fail_count <= 200)
         $error("%s: expected %0h, got %0h", field, want, got);
   endfunction

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin
      line_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         words_checked++;
         if (expected_words.size() == 0) begin
            flag_mismatch("unexpected word, kind", 0, rsp_chan.kind);
         end else begin
            want = expected_words.pop_front();
            if (rsp_chan.out_char !== want.out_char)
               flag_mismatch("out_char", want.out_char, rsp_chan.out_char);
            if (rsp_chan.kind !== want.kind)
               flag_mismatch("kind", want.kind, rsp_chan.kind);
            if (rsp_chan.line_empty !== want.line_empty)
               flag_mismatch("line_empty", want.line_empty, rsp_chan.line_empty);
            if (rsp_chan.line_number !== want.line_number)
               flag_mismatch("line_number", want.line_number, rsp_chan.line_number);
            if (rsp_chan.last !== want.last)
               flag_mismatch("last", want.last, rsp_chan.last);
         end
      end
   end

   // Watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      req_chan.valid   = 1'b0;
      req_chan.action  = ACT_BYTE;
      req_chan.in_char = CH_NONE;
      reset            = 1'b1;
      reset_splitter();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_line_breaks();
      test_blank_runs();
      test_quotes_and_comments();
      test_end_of_file();
      test_random_config();
      quiet = 1'b1;
      test_error_stop();
      req_chan.valid <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Sent %0d input words and checked %0d result words.", words_sent, words_checked);
      $display("Breaks, blanks, quotes, comments, end of file; run stopped by %s.",
               stop_kind.name());
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
